// File: sv/tgadec_pkg.sv
package tgadec_pkg;

	// palette depth default
	localparam int PALETTE_ENTRIES_DEF = 256;

	// queue depths
	localparam int IN_DEPTH  = 4;
	localparam int OUT_DEPTH = 4;

	// result status codes
	localparam logic [2:0] ST_RUN    = 3'd0;
	localparam logic [2:0] ST_DONE   = 3'd1;
	localparam logic [2:0] ST_SHORT  = 3'd2;
	localparam logic [2:0] ST_ID     = 3'd3;
	localparam logic [2:0] ST_UNSUP  = 3'd4;
	localparam logic [2:0] ST_BADPAL = 3'd5;
	localparam logic [2:0] ST_TRUNC  = 3'd6;

	// header byte positions
	localparam logic [4:0] HB_ID    = 5'd0;
	localparam logic [4:0] HB_TYPE  = 5'd2;
	localparam logic [4:0] HB_MS0   = 5'd3;
	localparam logic [4:0] HB_MS1   = 5'd4;
	localparam logic [4:0] HB_ML0   = 5'd5;
	localparam logic [4:0] HB_ML1   = 5'd6;
	localparam logic [4:0] HB_MD    = 5'd7;
	localparam logic [4:0] HB_W0    = 5'd12;
	localparam logic [4:0] HB_W1    = 5'd13;
	localparam logic [4:0] HB_H0    = 5'd14;
	localparam logic [4:0] HB_H1    = 5'd15;
	localparam logic [4:0] HB_PIX   = 5'd16;
	localparam logic [4:0] HB_DESC  = 5'd17;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_PALETTE,
		PH_PIXELS,
		PH_SKIP
	} phase_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] color;
		logic [15:0] x;
		logic [15:0] y;
		logic [7:0]  len;
		logic [15:0] width;
		logic [15:0] height;
	} res_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} req_t;

endpackage

// File: sv/tgadec_fifo.sv
module tgadec_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [W-1:0]                 wdata,
	output logic                         full,
	input  logic                         pop,
	output logic [W-1:0]                 rdata,
	output logic                         empty,
	output logic [$clog2(DEPTH+1)-1:0]   level
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign level   = cnt_q;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wdata;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == AW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= (rd_ptr_q == AW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule

// File: sv/tgadec_core.sv
module tgadec_core import tgadec_pkg::*; #(
	parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_wdata,
	input  logic req_vld,
	input  req_t req,
	output logic req_take,
	input  logic res_room,
	output logic res_vld,
	output res_t res
);
	localparam int AW = $clog2(PALETTE_ENTRIES);
	localparam int EW = $clog2(PALETTE_ENTRIES+1);

	logic         swap_q;
	phase_t       phase_q, phase_d;
	logic [4:0]   hcnt_q, hcnt_d;
	logic [7:0]   id_q, id_d, type_q, type_d, mdep_q, mdep_d, pdep_q, pdep_d;
	logic [15:0]  mstart_q, mstart_d, mlen_q, mlen_d, w_q, w_d, h_q, h_d;
	logic [EW-1:0] ent_q, ent_d;
	logic [1:0]   k_q, k_d, bip_q, bip_d;
	logic [23:0]  ca_q, ca_d;
	logic [7:0]   pr_q, pr_d;
	logic         isrun_q, isrun_d;
	logic [15:0]  col_q, col_d, src_q, src_d;

	logic [31:0]  pal_mem [PALETTE_ENTRIES];
	logic [PALETTE_ENTRIES-1:0] pal_vld_q;

	logic        fire, b_last, is8, is32, bad, err, complete, st_vld, run, pal_sel, pal_we;
	logic [7:0]  b, rl, n;
	logic [2:0]  st;
	logic [31:0] rc, pal_wdata, cpx;
	logic [15:0] rx, ry, hm1, room, col_new, yrle;

	// stage 2 registers
	logic        vld_s2, run_s2, sel_s2, pvld_s2, inrng_s2;
	res_t        res_s2;
	logic [31:0] rdata_s2, col_sel;

	assign b        = req.data;
	assign b_last   = req.last;
	assign fire     = req_vld && res_room;
	assign req_take = fire;

	assign is8  = (pdep_q == 8'd8) && (type_q[2:0] == 3'd1) && !type_q[3];
	assign is32 = (pdep_q == 8'd32) && (type_q[2:0] == 3'd2);
	assign bad  = is8 && !(mstart_q == '0 && mlen_q <= 16'(PALETTE_ENTRIES) && mdep_q == 8'd24);
	assign err  = (id_q != '0) || (!is8 && !is32) || bad;
	assign hm1  = h_q - 16'd1 - src_q;
	assign yrle = id_q[5] ? src_q : hm1;
	assign cpx  = {b, ca_q};
	assign pal_wdata = {8'hFF, b, ca_q[15:0]};

	// per-byte decode
	always_comb begin
		phase_d = phase_q; hcnt_d = hcnt_q; id_d = id_q; type_d = type_q;
		mdep_d = mdep_q; pdep_d = pdep_q; mstart_d = mstart_q; mlen_d = mlen_q;
		w_d = w_q; h_d = h_q; ent_d = ent_q; k_d = k_q; bip_d = bip_q; ca_d = ca_q;
		pr_d = pr_q; isrun_d = isrun_q; col_d = col_q; src_d = src_q;
		st_vld = 1'b0; st = ST_RUN; run = 1'b0; rc = '0; rx = '0; ry = '0; rl = '0;
		complete = 1'b0; pal_sel = 1'b0; pal_we = 1'b0;
		room = '0; n = '0; col_new = col_q;
		case (phase_q)
			PH_HEADER: begin
				case (hcnt_q)
					HB_ID:   id_d = b;
					HB_TYPE: type_d = b;
					HB_MS0:  mstart_d[7:0] = b;
					HB_MS1:  mstart_d[15:8] = b;
					HB_ML0:  mlen_d[7:0] = b;
					HB_ML1:  mlen_d[15:8] = b;
					HB_MD:   mdep_d = b;
					HB_W0:   w_d[7:0] = b;
					HB_W1:   w_d[15:8] = b;
					HB_H0:   h_d[7:0] = b;
					HB_H1:   h_d[15:8] = b;
					HB_PIX:  pdep_d = b;
					default: ;
				endcase
				if (hcnt_q != HB_DESC) begin
					hcnt_d = hcnt_q + 5'd1;
					if (b_last) begin
						st_vld = 1'b1; st = ST_SHORT; hcnt_d = '0;
					end
				end else begin
					hcnt_d = '0;
					if (err) begin
						st_vld = 1'b1;
						if (id_q != '0) st = ST_ID;
						else if (!is8 && !is32) st = ST_UNSUP;
						else st = ST_BADPAL;
						phase_d = b_last ? PH_HEADER : PH_SKIP;
					end else begin
						// descriptor replaces the id length byte
						id_d = b; ent_d = '0; k_d = '0; ca_d = '0; bip_d = '0;
						pr_d = '0; isrun_d = 1'b0; col_d = '0; src_d = '0;
						if (is8 && mlen_q != '0) phase_d = PH_PALETTE;
						else begin
							phase_d = PH_PIXELS;
							complete = (w_q == '0) || (h_q == '0);
						end
					end
				end
			end
			PH_PALETTE: begin
				// palette bytes come as blue, green, red
				case (k_q)
					2'd0: begin ca_d = {16'd0, b}; k_d = 2'd1; end
					2'd1: begin ca_d[15:8] = b; k_d = 2'd2; end
					default: begin
						pal_we = 1'b1; k_d = '0; ent_d = ent_q + 1'b1;
						if (16'(ent_q) + 16'd1 == mlen_q) begin
							phase_d = PH_PIXELS;
							complete = (w_q == '0) || (h_q == '0);
						end
					end
				endcase
			end
			PH_PIXELS: begin
				if (pdep_q == 8'd8) begin
					// indexed pixel: colour from the palette in stage 2
					run = 1'b1; pal_sel = 1'b1; rl = 8'd1; rx = col_q; ry = hm1;
					col_new = col_q + 16'd1;
					col_d = col_new;
					if (col_new >= w_q) begin
						col_d = '0; src_d = src_q + 16'd1;
						complete = (src_q + 16'd1) >= h_q;
					end
				end else if (!type_q[3] || pr_q != '0) begin
					if (bip_q != 2'd3) begin
						case (bip_q)
							2'd0:    ca_d = {16'd0, b};
							2'd1:    ca_d[15:8] = b;
							default: ca_d[23:16] = b;
						endcase
						bip_d = bip_q + 2'd1;
					end else if (!type_q[3]) begin
						// raw truecolor pixel
						bip_d = '0; run = 1'b1; rc = cpx; rl = 8'd1; rx = col_q; ry = hm1;
						col_new = col_q + 16'd1;
						col_d = col_new;
						if (col_new >= w_q) begin
							col_d = '0; src_d = src_q + 16'd1;
							complete = (src_q + 16'd1) >= h_q;
						end
					end else begin
						// RLE pixel, cut at the row end
						bip_d = '0;
						if (isrun_q) begin
							room = (col_q < w_q) ? w_q - col_q : '0;
							n = (16'(pr_q) > room) ? room[7:0] : pr_q;
							if (n != '0) begin
								run = 1'b1; rc = cpx; rl = n; rx = col_q; ry = yrle;
							end
							col_new = col_q + 16'(n);
							pr_d = '0;
						end else begin
							if (col_q < w_q) begin
								run = 1'b1; rc = cpx; rl = 8'd1; rx = col_q; ry = yrle;
								col_new = col_q + 16'd1;
							end
							pr_d = pr_q - 8'd1;
						end
						col_d = col_new;
						if (pr_d == '0 && col_new >= w_q) begin
							col_d = '0; src_d = src_q + 16'd1;
							complete = (src_q + 16'd1) >= h_q;
						end
					end
				end else begin
					// RLE packet header
					isrun_d = b[7];
					pr_d = {1'b0, b[6:0]} + 8'd1;
					bip_d = '0;
				end
			end
			default: begin
				if (b_last) phase_d = PH_HEADER;
			end
		endcase
		if (complete) begin
			st_vld = 1'b1; st = ST_DONE;
			phase_d = b_last ? PH_HEADER : PH_SKIP;
		end else if (!st_vld && b_last && (phase_d == PH_PALETTE || phase_d == PH_PIXELS)) begin
			st_vld = 1'b1; st = ST_TRUNC; phase_d = PH_HEADER;
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap_q <= 1'b0; phase_q <= PH_HEADER; hcnt_q <= '0; id_q <= '0; type_q <= '0;
			mdep_q <= '0; pdep_q <= '0; mstart_q <= '0; mlen_q <= '0; w_q <= '0; h_q <= '0;
			ent_q <= '0; k_q <= '0; bip_q <= '0; ca_q <= '0; pr_q <= '0; isrun_q <= 1'b0;
			col_q <= '0; src_q <= '0; pal_vld_q <= '0; vld_s2 <= 1'b0;
		end else begin
			if (cfg_we) swap_q <= cfg_wdata;
			vld_s2 <= fire && (st_vld || run);
			if (fire) begin
				phase_q <= phase_d; hcnt_q <= hcnt_d; id_q <= id_d; type_q <= type_d;
				mdep_q <= mdep_d; pdep_q <= pdep_d; mstart_q <= mstart_d; mlen_q <= mlen_d;
				w_q <= w_d; h_q <= h_d; ent_q <= ent_d; k_q <= k_d; bip_q <= bip_d;
				ca_q <= ca_d; pr_q <= pr_d; isrun_q <= isrun_d; col_q <= col_d; src_q <= src_d;
				if (pal_we) pal_vld_q[ent_q[AW-1:0]] <= 1'b1;
			end
		end
	end

	// palette memory, registered read
	always_ff @(posedge clk) begin
		if (fire && pal_we) pal_mem[ent_q[AW-1:0]] <= pal_wdata;
		if (fire) begin
			rdata_s2 <= pal_mem[b[AW-1:0]];
			pvld_s2  <= pal_vld_q[b[AW-1:0]];
			inrng_s2 <= {1'b0, b} < 9'(PALETTE_ENTRIES);
			run_s2   <= run;
			sel_s2   <= pal_sel;
			res_s2.status <= st_vld ? st : ST_RUN;
			res_s2.color  <= rc;
			res_s2.x      <= rx;
			res_s2.y      <= ry;
			res_s2.len    <= rl;
			res_s2.width  <= (st_vld && st == ST_DONE) ? w_d : '0;
			res_s2.height <= (st_vld && st == ST_DONE) ? h_d : '0;
		end
	end

	// colour select and red/blue swap
	always_comb begin
		col_sel = sel_s2 ? ((pvld_s2 && inrng_s2) ? rdata_s2 : '0) : res_s2.color;
		if (run_s2 && swap_q) col_sel = {col_sel[31:24], col_sel[7:0], col_sel[15:8], col_sel[23:16]};
		res = res_s2;
		res.color = col_sel;
	end

	assign res_vld = vld_s2;
endmodule

// File: sv/tga_image_stream_decoder.sv
// TGA byte-stream decoder: one file byte accepted per cycle while the result queue has room.
// Path: a request is held in the input queue, is taken into the decode stage
// register (decode stage with palette read), and its result is then written
// into the output queue, where it is ready to pop.
// Throughput: one byte per cycle while the result queue has room, set by the single decode stage.
// Reset: asynchronous, active low; expects a new header, palette reads 0.
module tga_image_stream_decoder import tgadec_pkg::*; #(
	parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        swap_red_blue_wr,
	input  logic        swap_red_blue,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  status,
	output logic [31:0] pixel_color,
	output logic [15:0] pixel_x,
	output logic [15:0] pixel_y,
	output logic [7:0]  run_length,
	output logic [15:0] image_width,
	output logic [15:0] image_height
);
	localparam int ICW = $clog2(IN_DEPTH+1);
	localparam int OCW = $clog2(OUT_DEPTH+1);

	req_t           in_w, in_r;
	logic           in_empty, take;
	logic [ICW-1:0] in_lvl;
	res_t           res, out_r;
	logic           res_vld, out_full, room;
	logic [OCW-1:0] out_lvl;

	assign in_w.data = data_byte;
	assign in_w.last = last_byte;

	// front: request queue
	tgadec_fifo #(.W($bits(req_t)), .DEPTH(IN_DEPTH)) u_in (
		.clk, .arst_n, .push, .wdata(in_w), .full, .pop(take),
		.rdata(in_r), .empty(in_empty), .level(in_lvl)
	);

	// keep a slot free for the result still in flight
	assign room = (out_lvl <= OCW'(OUT_DEPTH-2)) && (in_lvl != '0);

	// back: decoder
	tgadec_core #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_core (
		.clk, .arst_n, .cfg_we(swap_red_blue_wr), .cfg_wdata(swap_red_blue),
		.req_vld(!in_empty), .req(in_r), .req_take(take),
		.res_room(room), .res_vld, .res
	);

	// result queue
	tgadec_fifo #(.W($bits(res_t)), .DEPTH(OUT_DEPTH)) u_out (
		.clk, .arst_n, .push(res_vld), .wdata(res), .full(out_full), .pop,
		.rdata(out_r), .empty, .level(out_lvl)
	);

	assign status       = out_r.status;
	assign pixel_color  = out_full ? out_r.color : out_r.color;
	assign pixel_x      = out_r.x;
	assign pixel_y      = out_r.y;
	assign run_length   = out_r.len;
	assign image_width  = out_r.width;
	assign image_height = out_r.height;
endmodule
